>>> design/newton_cubic_root_classifier_core_assert.svh
// Assertion macros for the Newton cube-root classifier.
// Included by modules that check their own control logic.
`ifndef NEWTON_CUBIC_ROOT_CLASSIFIER_CORE_ASSERT_SVH
`define NEWTON_CUBIC_ROOT_CLASSIFIER_CORE_ASSERT_SVH
`ifndef ASSERT_OFF
`define NCRC_ASSERT_IMPL(label, clk, rst, prop) \
   label: assert property (@(posedge clk) disable iff (rst) prop) \
      else $error("assertion failed");
`define NCRC_ASSERT_ALWAYS(label, clk, prop) \
   label: assert property (@(posedge clk) prop) else $error("assertion failed");
`else
`define NCRC_ASSERT_IMPL(label, clk, rst, prop)
`define NCRC_ASSERT_ALWAYS(label, clk, prop)
`endif
`endif

>>> design/ncrc_pkg.sv
// Shared types and constants for the Newton cube-root classifier.
// No dependencies.
package ncrc_pkg;
   localparam int BASE_ITERATIONS_DEF     = 60;
   localparam int EXTRA_ITERATION_CAP_DEF = 20;
   localparam int FRACTION_BITS_DEF       = 28;
   localparam int ZoomWidth               = 11;
   localparam int IterWidth               = 9;
   localparam logic [2:0] CLS_ROOT0  = 3'd0;
   localparam logic [2:0] CLS_UPPER  = 3'd1;
   localparam logic [2:0] CLS_LOWER  = 3'd2;
   localparam logic [2:0] CLS_EQUAL  = 3'd3;
   localparam logic [2:0] CLS_BLACK  = 3'd4;

   // Datapath micro-ops issued by the controller.
   typedef enum logic [3:0] {
      OP_NONE, OP_LOAD, OP_NORM, OP_DIVR, OP_DIVI, OP_SCALE, OP_MUL, OP_SUM,
      OP_DIVRE, OP_DIVIM, OP_SAT, OP_CLS
   } op_type;

   typedef struct packed {
      op_type op;
      logic   step;   // one cycle of the current multi-cycle op
   } dp_cmd_type;

   typedef struct packed {
      logic zero_den;
      logic busy;     // multi-cycle op not finished
   } dp_status_type;

   function automatic logic [23:0] class_color(input logic [2:0] cls);
      logic [23:0] c;
      c = 24'h000000;
      case (cls)
         CLS_ROOT0: c = 24'hFF0000;
         CLS_UPPER: c = 24'h0000FF;
         CLS_LOWER: c = 24'h00FF00;
         CLS_EQUAL: c = 24'hFFFF00;
         default:   c = 24'h000000;
      endcase
      return c;
   endfunction
endpackage

>>> design/ncrc_datapath.sv
// Datapath: shared restoring divider, divide-by-three unit, a 32x32 multiplier plus two squarers, classifier.
// Depends on ncrc_pkg.
module ncrc_datapath import ncrc_pkg::*; #(
   parameter int FRACTION_BITS = FRACTION_BITS_DEF
) (
   input  logic                 clock,
   input  logic                 reset,
   input  dp_cmd_type           cmd,
   input  logic signed [31:0]   load_real,
   input  logic signed [31:0]   load_imag,
   output dp_status_type        status,
   output logic [2:0]           cls_out
);
   localparam int NW = 128;
   localparam int DW = 64;
   localparam int CW = 8;
   localparam logic [33:0] RECIP3 = 34'h2_AAAA_AAAB;   // ceil(2^35 / 3)

   logic signed [31:0] a_ff, a_in, b_ff, b_in;
   logic [63:0] m_ff, m_in;
   logic [63:0] vr_ff, vr_in, vi_ff, vi_in;
   logic [NW-1:0] num_ff, num_in, q_ff, q_in;
   logic [DW:0]   rem_ff, rem_in;
   logic [63:0]   dvs_ff, dvs_in;
   logic [CW-1:0] cnt_ff, cnt_in;
   logic          busy_ff, busy_in;
   logic [127:0]  acc_ff, acc_in;
   logic [127:0]  rr_ff, rr_in, ii_ff, ii_in, ri_ff, ri_in;
   logic          ren_ff, ren_in, imn_ff, imn_in;
   logic [127:0]  rem_re_ff, rem_re_in;
   logic [1:0]    r3_ff, r3_in;
   logic [3:0]    mcnt_ff, mcnt_in;
   logic [2:0]    cls_ff, cls_in;

   logic [63:0]  ua, ub;
   logic [63:0]  mop_a, mop_b, pp;
   logic [DW:0]  rem_sh;
   logic         rem_ge;
   logic [33:0]  d3_x;
   logic [67:0]  d3_p;
   logic [31:0]  d3_q;
   logic [1:0]   d3_r;
   logic [127:0] t_re, t_im;
   logic         re_neg, im_neg;
   logic [127:0] re_mag, im_mag, tmp;
   logic         tn;
   logic [31:0]  mul_x, mul_y;
   logic [63:0]  mul_p;
   logic [127:0] mul_sh;
   logic [63:0]  sq_a, sq_b;
   logic [65:0]  x3, y2;
   logic d01, d02, d10, d20;

   assign ua = a_ff[31] ? 64'(-$signed({{32{a_ff[31]}}, a_ff})) : {32'd0, a_ff};
   assign ub = b_ff[31] ? 64'(-$signed({{32{b_ff[31]}}, b_ff})) : {32'd0, b_ff};

   // restoring division step
   assign rem_sh = {rem_ff[DW-1:0], num_ff[NW-1]};
   assign rem_ge = rem_sh >= {1'b0, dvs_ff};

   // divide by three, 32 bits per cycle: remainder of 0..2 carried into the next chunk
   assign d3_x = {r3_ff, num_ff[NW-1:NW-32]};
   assign d3_p = {34'd0, d3_x} * {34'd0, RECIP3};
   assign d3_q = d3_p[66:35];
   assign d3_r = d3_x[1:0] - d3_q[1:0] - {d3_q[0], 1'b0};

   // 32x32 multiply of selected halves
   always_comb begin
      mop_a = vr_ff; mop_b = vr_ff;
      case (mcnt_ff[3:2])
         2'd0: begin mop_a = vr_ff; mop_b = vr_ff; end
         2'd1: begin mop_a = vi_ff; mop_b = vi_ff; end
         2'd2: begin mop_a = vr_ff; mop_b = vi_ff; end
         default: begin mop_a = ua; mop_b = ua; end
      endcase
      mul_x = mcnt_ff[1] ? mop_a[63:32] : mop_a[31:0];
      mul_y = mcnt_ff[0] ? mop_b[63:32] : mop_b[31:0];
   end
   assign mul_p  = {32'd0, mul_x} * {32'd0, mul_y};
   assign pp     = mul_p;
   assign mul_sh = {64'd0, pp} << (32 * (32'(mcnt_ff[1]) + 32'(mcnt_ff[0])));

   // squares of |a| and |b|, shared by the norm and the classifier
   assign sq_a = {32'd0, ua[31:0]} * {32'd0, ua[31:0]};
   assign sq_b = {32'd0, ub[31:0]} * {32'd0, ub[31:0]};

   assign t_re = {64'd0, ua} << (FRACTION_BITS + 1);
   assign t_im = {64'd0, ub} << (FRACTION_BITS + 1);

   always_comb begin
      // real: t + rr - ii
      if (!a_ff[31]) begin
         tmp = t_re + rr_ff; tn = 1'b0;
      end else if (t_re >= rr_ff) begin
         tmp = t_re - rr_ff; tn = 1'b1;
      end else begin
         tmp = rr_ff - t_re; tn = 1'b0;
      end
      if (tn) begin
         re_mag = tmp + ii_ff; re_neg = 1'b1;
      end else if (tmp >= ii_ff) begin
         re_mag = tmp - ii_ff; re_neg = 1'b0;
      end else begin
         re_mag = ii_ff - tmp; re_neg = 1'b1;
      end
      // imag: t + 2*vr*vi with sign
      if (b_ff[31] == (a_ff[31] != (b_ff > 0))) begin
         im_mag = t_im + {ri_ff[126:0], 1'b0}; im_neg = b_ff[31];
      end else if (t_im >= {ri_ff[126:0], 1'b0}) begin
         im_mag = t_im - {ri_ff[126:0], 1'b0}; im_neg = b_ff[31];
      end else begin
         im_mag = {ri_ff[126:0], 1'b0} - t_im; im_neg = !b_ff[31];
      end
   end

   // classification compares
   assign x3 = {2'b0, sq_a} + {1'b0, sq_a, 1'b0};
   assign y2 = {2'b0, sq_b};

   function automatic logic s3gt(input logic xs, input logic xz, input logic ys,
                                 input logic [65:0] x3v, input logic [65:0] y2v);
      logic r;
      logic xpos, xneg, yneg;
      xpos = !xs && !xz; xneg = xs; yneg = ys;
      if ((xpos || xz) && yneg) r = 1'b1;
      else if ((xneg || xz) && !yneg) r = 1'b0;
      else r = xpos ? (x3v > y2v) : (x3v < y2v);
      return r;
   endfunction

   always_comb begin
      logic az, bz;
      az = (a_ff == 0); bz = (b_ff == 0);
      d01 = s3gt(a_ff[31], az, b_ff[31], x3, y2);
      d02 = s3gt(a_ff[31], az, !b_ff[31] && !bz, x3, y2);
      d10 = s3gt(!a_ff[31] && !az, az, !b_ff[31] && !bz, x3, y2);
      d20 = s3gt(!a_ff[31] && !az, az, b_ff[31], x3, y2);
   end

   function automatic logic [31:0] sat32(input logic neg, input logic [127:0] mag);
      logic [31:0] r;
      if (mag[127:31] != 0) r = neg ? 32'h8000_0000 : 32'h7FFF_FFFF;
      else r = neg ? 32'(-$signed({1'b0, mag[30:0]})) : {1'b0, mag[30:0]};
      return r;
   endfunction

   always_comb begin
      a_in = a_ff; b_in = b_ff; m_in = m_ff; vr_in = vr_ff; vi_in = vi_ff;
      num_in = num_ff; q_in = q_ff; rem_in = rem_ff; dvs_in = dvs_ff;
      cnt_in = cnt_ff; busy_in = 1'b0; acc_in = acc_ff;
      rr_in = rr_ff; ii_in = ii_ff; ri_in = ri_ff; ren_in = ren_ff; imn_in = imn_ff;
      rem_re_in = rem_re_ff; r3_in = r3_ff; mcnt_in = mcnt_ff; cls_in = cls_ff;
      case (cmd.op)
         OP_LOAD: begin
            a_in = load_real; b_in = load_imag;
         end
         OP_NORM: begin
            // M = ua^2 + ub^2
            m_in = sq_a + sq_b;
         end
         OP_DIVR, OP_DIVI: begin
            if (!cmd.step) begin
               if (cmd.op == OP_DIVR) num_in = {64'd0, ua} << (2 * FRACTION_BITS);
               else num_in = {64'd0, ub} << (2 * FRACTION_BITS);
               dvs_in = m_ff;
               rem_in = '0; q_in = '0; cnt_in = CW'(NW - 1); busy_in = 1'b1;
            end else begin
               rem_in = rem_ge ? rem_sh - {1'b0, dvs_ff} : rem_sh;
               q_in   = {q_ff[NW-2:0], rem_ge};
               num_in = {num_ff[NW-2:0], 1'b0};
               cnt_in = cnt_ff - 1'b1;
               busy_in = (cnt_ff != 0);
               if (cnt_ff == 0) begin
                  if (cmd.op == OP_DIVR) begin
                     vr_in = q_in[63:0]; acc_in = q_in;
                  end else vi_in = q_in[63:0];
               end
            end
         end
         OP_DIVRE, OP_DIVIM: begin
            // divide by 3 * 2^FRACTION_BITS: shift, then the divide by three
            if (!cmd.step) begin
               if (cmd.op == OP_DIVRE) num_in = rem_re_ff >> FRACTION_BITS;
               else num_in = acc_ff >> FRACTION_BITS;
               r3_in = '0; q_in = '0; cnt_in = CW'(NW / 32 - 1); busy_in = 1'b1;
            end else begin
               r3_in  = d3_r;
               q_in   = {q_ff[NW-33:0], d3_q};
               num_in = {num_ff[NW-33:0], 32'd0};
               cnt_in = cnt_ff - 1'b1;
               busy_in = (cnt_ff != 0);
               if (cnt_ff == 0) begin
                  if (cmd.op == OP_DIVRE) rem_re_in = q_in;
                  else acc_in = q_in;
               end
            end
         end
         OP_SCALE: begin
            // halve both until below 2^62
            if (acc_ff[127:62] != 0 || q_ff[127:62] != 0) begin
               acc_in = acc_ff >> 1; q_in = q_ff >> 1; busy_in = 1'b1;
            end else begin
               vr_in = acc_ff[63:0]; vi_in = q_ff[63:0];
            end
         end
         OP_MUL: begin
            if (!cmd.step) begin
               mcnt_in = '0; rr_in = '0; ii_in = '0; ri_in = '0; busy_in = 1'b1;
            end else begin
               case (mcnt_ff[3:2])
                  2'd0:    rr_in = rr_ff + mul_sh;
                  2'd1:    ii_in = ii_ff + mul_sh;
                  default: ri_in = ri_ff + mul_sh;
               endcase
               mcnt_in = mcnt_ff + 1'b1;
               busy_in = (mcnt_ff != 4'd11);
            end
         end
         OP_SUM: begin
            rem_re_in = re_mag; ren_in = re_neg; acc_in = im_mag; imn_in = im_neg;
         end
         OP_SAT: begin
            a_in = sat32(ren_ff, rem_re_ff);
            b_in = sat32(imn_ff, acc_ff);
         end
         OP_CLS: begin
            if (d01 && d02) cls_in = CLS_ROOT0;
            else if (d10 && !b_ff[31] && b_ff != 0) cls_in = CLS_UPPER;
            else if (d20 && b_ff[31]) cls_in = CLS_LOWER;
            else if (a_ff == 0 && b_ff == 0) cls_in = CLS_EQUAL;
            else cls_in = CLS_BLACK;
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      a_ff <= a_in; b_ff <= b_in; m_ff <= m_in; vr_ff <= vr_in; vi_ff <= vi_in;
      num_ff <= num_in; q_ff <= q_in; rem_ff <= rem_in; dvs_ff <= dvs_in;
      cnt_ff <= cnt_in; acc_ff <= acc_in; rr_ff <= rr_in; ii_ff <= ii_in;
      ri_ff <= ri_in; ren_ff <= ren_in; imn_ff <= imn_in; rem_re_ff <= rem_re_in;
      r3_ff <= r3_in; mcnt_ff <= mcnt_in; cls_ff <= cls_in;
      if (reset) busy_ff <= 1'b0; else busy_ff <= busy_in;
   end

   assign status.zero_den = (m_ff == 0);
   assign status.busy     = busy_ff;
   assign cls_out         = cls_ff;
endmodule

>>> design/ncrc_ctrl.sv
// Controller: sequences iterations and datapath ops, owns the handshakes.
// Depends on ncrc_pkg and the assertion macro header.
`include "newton_cubic_root_classifier_core_assert.svh"
module ncrc_ctrl import ncrc_pkg::*; #(
   parameter int BASE_ITERATIONS     = BASE_ITERATIONS_DEF,
   parameter int EXTRA_ITERATION_CAP = EXTRA_ITERATION_CAP_DEF
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        in_valid,
   output logic                        in_ready,
   output logic                        out_valid,
   input  logic                        out_ready,
   input  logic signed [ZoomWidth-1:0] zoom,
   input  dp_status_type               status,
   input  logic [2:0]                  dp_cls,
   output dp_cmd_type                  cmd,
   output logic [2:0]                  cls_out
);
   typedef enum logic [12:0] {
      S_IDLE  = 13'b0000000000001, S_NORM  = 13'b0000000000010,
      S_CHK   = 13'b0000000000100, S_DIVR  = 13'b0000000001000,
      S_DIVI  = 13'b0000000010000, S_SCALE = 13'b0000000100000,
      S_MUL   = 13'b0000001000000, S_SUM   = 13'b0000010000000,
      S_DIVRE = 13'b0000100000000, S_DIVIM = 13'b0001000000000,
      S_SAT   = 13'b0010000000000, S_CLS   = 13'b0100000000000,
      S_OUT   = 13'b1000000000000
   } state_type;

   state_type state_ff, state_in;
   logic [IterWidth-1:0] iter_ff, iter_in;
   logic started_ff, started_in;
   logic ov_ff, ov_in;
   logic [2:0] cls_ff, cls_in;
   logic [ZoomWidth-1:0] zmag;
   logic [ZoomWidth-1:0] extra;
   logic [IterWidth-1:0] total;

   assign zmag  = zoom[ZoomWidth-1] ? ZoomWidth'(-zoom) : ZoomWidth'(zoom);
   assign extra = ((zmag >> 1) > ZoomWidth'(EXTRA_ITERATION_CAP)) ?
                  ZoomWidth'(EXTRA_ITERATION_CAP) : (zmag >> 1);
   assign total = IterWidth'(BASE_ITERATIONS) + IterWidth'(extra);

   always_comb begin
      state_in = state_ff; iter_in = iter_ff; started_in = 1'b0; ov_in = ov_ff;
      cls_in = cls_ff; cmd.op = OP_NONE; cmd.step = 1'b0;
      case (state_ff)
         S_IDLE: if (in_valid) begin
            cmd.op = OP_LOAD; iter_in = total; state_in = S_NORM;
         end
         S_NORM: begin cmd.op = OP_NORM; state_in = S_CHK; end
         S_CHK: begin
            if (status.zero_den) begin
               cls_in = CLS_BLACK; ov_in = 1'b1; state_in = S_OUT;
            end else state_in = S_DIVR;
         end
         S_DIVR, S_DIVI, S_DIVRE, S_DIVIM, S_MUL: begin
            case (state_ff)
               S_DIVR:  cmd.op = OP_DIVR;
               S_DIVI:  cmd.op = OP_DIVI;
               S_DIVRE: cmd.op = OP_DIVRE;
               S_DIVIM: cmd.op = OP_DIVIM;
               default: cmd.op = OP_MUL;
            endcase
            cmd.step = started_ff;
            started_in = 1'b1;
            if (started_ff && !status.busy) begin
               // op finished last cycle: no further step
               cmd.op = OP_NONE; cmd.step = 1'b0;
               started_in = 1'b0;
               case (state_ff)
                  S_DIVR:  state_in = S_DIVI;
                  S_DIVI:  state_in = S_SCALE;
                  S_MUL:   state_in = S_SUM;
                  S_DIVRE: state_in = S_DIVIM;
                  default: state_in = S_SAT;
               endcase
            end
         end
         S_SCALE: begin
            cmd.op = OP_SCALE; started_in = 1'b1;
            if (started_ff && !status.busy) begin
               started_in = 1'b0; state_in = S_MUL;
            end
         end
         S_SUM: begin cmd.op = OP_SUM; state_in = S_DIVRE; end
         S_SAT: begin
            cmd.op = OP_SAT; iter_in = iter_ff - 1'b1;
            state_in = (iter_ff == 1) ? S_CLS : S_NORM;
         end
         S_CLS: begin cmd.op = OP_CLS; state_in = S_OUT; end
         S_OUT: begin
            if (!ov_ff) begin cls_in = dp_cls; ov_in = 1'b1; end
            else if (out_ready) begin ov_in = 1'b0; state_in = S_IDLE; end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE; started_ff <= 1'b0; ov_ff <= 1'b0;
      end else begin
         state_ff <= state_in; started_ff <= started_in; ov_ff <= ov_in;
      end
      iter_ff <= iter_in; cls_ff <= cls_in;
   end

   assign in_ready  = (state_ff == S_IDLE);
   assign out_valid = ov_ff && (state_ff == S_OUT);
   assign cls_out   = cls_ff;

   `NCRC_ASSERT_IMPL(a_no_accept_busy, clock, reset, out_valid |-> !in_ready)
   `NCRC_ASSERT_IMPL(a_out_hold, clock, reset,
      (out_valid && !out_ready) |=> (out_valid && $stable(cls_out)))
   `NCRC_ASSERT_IMPL(a_iter_nonzero, clock, reset,
      (state_ff == S_SAT) |-> (iter_ff != 0))
endmodule

>>> design/newton_cubic_root_classifier_core.sv
// Newton cube-root classifier: z <- (2z^3+1)/(3z^2), nearest root of unity.
// Input beat: req_tdata = {start_imag, start_real} (start_real in bits 31:0).
// Output beat: rsp_tdata = {5'b0, pixel_color, root_class} (class in bits 2:0).
// csr_we/csr_wdata write zoom_level; its magnitude halved (capped) adds
// iterations to the base count. Write it only while no pixel is in flight.
// One pixel at a time. An iteration runs two reciprocal divides on the
// shared bit-serial divider (128 quotient bits), two divides by three (32
// bits per cycle), a multiply pass and the control states, plus a halving
// step in S_SCALE per halving when FRACTION_BITS > 30. A pixel runs N
// iterations, N being 60 plus the zoom extra (at most 80). With rsp_tready
// high the next request is taken in the cycle after the result beat.
// A zero |z|^2 at any iteration ends the pixel early as class 4.
// Reset returns the controller to idle and clears zoom_level; no result is
// pending after reset.
// The result beat holds until rsp_tready; no new request is accepted until
// the result beat is taken.
// Depends on ncrc_pkg, ncrc_ctrl, ncrc_datapath.
module newton_cubic_root_classifier_core import ncrc_pkg::*; #(
   parameter int BASE_ITERATIONS     = BASE_ITERATIONS_DEF,
   parameter int EXTRA_ITERATION_CAP = EXTRA_ITERATION_CAP_DEF,
   parameter int FRACTION_BITS       = FRACTION_BITS_DEF
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [63:0] req_tdata,   // start_real, start_imag
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [31:0] rsp_tdata,   // root_class, pixel_color, zero pad
   input  logic        csr_we,
   input  logic [10:0] csr_wdata    // zoom_level
);
   logic signed [ZoomWidth-1:0] zoom_ff;
   dp_cmd_type    cmd;
   dp_status_type status;
   logic [2:0]    dp_cls, cls;

   always_ff @(posedge clock) begin
      if (reset) zoom_ff <= '0;
      else if (csr_we) zoom_ff <= csr_wdata;
   end

   ncrc_ctrl #(
      .BASE_ITERATIONS(BASE_ITERATIONS), .EXTRA_ITERATION_CAP(EXTRA_ITERATION_CAP)
   ) u_ctrl (
      .clock, .reset, .in_valid(req_tvalid), .in_ready(req_tready),
      .out_valid(rsp_tvalid), .out_ready(rsp_tready), .zoom(zoom_ff),
      .status, .dp_cls, .cmd, .cls_out(cls)
   );

   ncrc_datapath #(.FRACTION_BITS(FRACTION_BITS)) u_dp (
      .clock, .reset, .cmd, .load_real(req_tdata[31:0]), .load_imag(req_tdata[63:32]),
      .status, .cls_out(dp_cls)
   );

   assign rsp_tdata = {5'd0, class_color(cls), cls};
endmodule

>>> bench/tb_newton_cubic_root_classifier_core.sv
// Self-checking bench for newton_cubic_root_classifier_core: a queue-fed stream driver,
// a result monitor and an exact fixed-point Newton predictor, across several zoom settings.
// Depends on ncrc_pkg and the core RTL.
module tb_newton_cubic_root_classifier_core;
   import ncrc_pkg::*;

   localparam int FRAC = FRACTION_BITS_DEF;
   localparam longint CYCLE_LIMIT = 200_000_000;
   localparam logic [23:0] RED = 24'hFF0000, BLUE = 24'h0000FF, GREEN = 24'h00FF00;
   localparam logic [23:0] YELLOW = 24'hFFFF00, BLACK = 24'h000000;

   typedef struct packed {
      logic [2:0]  root_class;
      logic [23:0] pixel_color;
   } pixel_result_t;

   logic        clock, reset;
   logic        req_tvalid, req_tready, rsp_tvalid, rsp_tready, csr_we;
   logic [63:0] req_tdata;   // start_real, start_imag
   logic [31:0] rsp_tdata;   // root_class, pixel_color, zero pad
   logic [10:0] csr_wdata;   // zoom_level

   logic [63:0]   start_q[$];
   pixel_result_t pixel_q[$];
   logic signed [10:0] zoom_shadow;
   int errors, issued, accepted, gap_left, burst_left, run_left;
   longint cycles;

   newton_cubic_root_classifier_core uut (
      .clock(clock), .reset(reset),
      .req_tvalid(req_tvalid), .req_tready(req_tready), .req_tdata(req_tdata),
      .rsp_tvalid(rsp_tvalid), .rsp_tready(rsp_tready), .rsp_tdata(rsp_tdata),
      .csr_we(csr_we), .csr_wdata(csr_wdata)
   );

   always begin
      clock = 1'b1; #1;
      clock = 1'b0; #1;
   end

   function automatic logic sqrt3_gt(input logic signed [63:0] x, input logic signed [63:0] y);
      logic [63:0] ux, uy;
      if (x >= 0 && y < 0) return 1'b1;
      if (x <= 0 && y >= 0) return 1'b0;
      ux = x < 0 ? -x : x;
      uy = y < 0 ? -y : y;
      return (x > 0) ? (3 * ux * ux > uy * uy) : (3 * ux * ux < uy * uy);
   endfunction

   function automatic logic signed [63:0] sat_div3(input logic signed [129:0] num);
      logic [129:0] mag, q;
      mag = num < 0 ? -num : num;
      q = mag / (130'd3 << FRAC);
      if (q >= 130'h8000_0000) return num < 0 ? -64'sh8000_0000 : 64'sh7FFF_FFFF;
      return num < 0 ? -$signed({1'b0, q[62:0]}) : $signed({1'b0, q[62:0]});
   endfunction

   function automatic pixel_result_t classify_pixel(input logic [63:0] start,
                                                    input logic signed [10:0] zoom);
      logic signed [63:0]  a, b;
      logic [63:0]         ua, ub, m;
      logic [127:0]        qr, qi;
      logic signed [129:0] vr, vi, aw, bw;
      int                  z, extra, n, i;
      logic                dead;
      pixel_result_t       r;
      a = $signed(start[31:0]);
      b = $signed(start[63:32]);
      z = zoom;
      extra = (z < 0 ? -z : z) / 2;
      if (extra > EXTRA_ITERATION_CAP_DEF) extra = EXTRA_ITERATION_CAP_DEF;
      n = BASE_ITERATIONS_DEF + extra;
      dead = 1'b0;
      for (i = 0; i < n && !dead; i++) begin
         ua = a < 0 ? -a : a;
         ub = b < 0 ? -b : b;
         m = ua * ua + ub * ub;
         if (m == 0) begin
            dead = 1'b1;
         end else begin
            qr = ({64'b0, ua} << (2 * FRAC)) / {64'b0, m};
            qi = ({64'b0, ub} << (2 * FRAC)) / {64'b0, m};
            while ((qr >> 62) != 0 || (qi >> 62) != 0) begin
               qr = qr >> 1;
               qi = qi >> 1;
            end
            vr = $signed({2'b0, qr});
            vi = $signed({2'b0, qi});
            if (a < 0) vr = -vr;
            if (b > 0) vi = -vi;
            aw = a;
            bw = b;
            a = sat_div3((aw <<< (FRAC + 1)) + vr * vr - vi * vi);
            b = sat_div3((bw <<< (FRAC + 1)) + ((vr * vi) <<< 1));
         end
      end
      if (dead) r.root_class = CLS_BLACK;
      else if (sqrt3_gt(a, b) && sqrt3_gt(a, -b)) r.root_class = CLS_ROOT0;
      else if (sqrt3_gt(-a, -b) && b > 0) r.root_class = CLS_UPPER;
      else if (sqrt3_gt(-a, b) && b < 0) r.root_class = CLS_LOWER;
      else if (a == 0 && b == 0) r.root_class = CLS_EQUAL;
      else r.root_class = CLS_BLACK;
      case (r.root_class)
         CLS_ROOT0: r.pixel_color = RED;
         CLS_UPPER: r.pixel_color = BLUE;
         CLS_LOWER: r.pixel_color = GREEN;
         CLS_EQUAL: r.pixel_color = YELLOW;
         default:   r.pixel_color = BLACK;
      endcase
      return r;
   endfunction

   function automatic logic [31:0] rand_coord();
      logic signed [31:0] v;
      v = $urandom;
      case ($urandom_range(0, 5))
         0:       return v;
         1:       return 32'sd0;
         default: return v >>> $urandom_range(1, 12);
      endcase
   endfunction

   // driver
   always @(negedge clock) begin
      logic v;
      v = req_tvalid;
      if (!reset) begin
         if (v && accepted == issued) v = 1'b0;
         if (!v) begin
            if (gap_left > 0) begin
               gap_left--;
            end else if (start_q.size() > 0) begin
               req_tdata <= start_q.pop_front();
               v = 1'b1;
               issued++;
               if (burst_left > 0) begin
                  burst_left--;
               end else begin
                  burst_left = $urandom_range(0, 6);
                  gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 40);
               end
            end
         end
         if (run_left > 0) begin
            run_left--;
         end else begin
            rsp_tready <= !rsp_tready;
            run_left = $urandom_range(0, 1) ? $urandom_range(0, 5) : $urandom_range(20, 200);
         end
      end
      req_tvalid <= v;
   end

   // monitor and scoreboard
   always @(posedge clock) begin
      pixel_result_t got, want;
      if (!reset) begin
         cycles++;
         if (req_tvalid && req_tready) begin
            pixel_q.push_back(classify_pixel(req_tdata, zoom_shadow));
            accepted++;
         end
         if (rsp_tvalid && rsp_tready) begin
            got.root_class = rsp_tdata[2:0];
            got.pixel_color = rsp_tdata[26:3];
            if (pixel_q.size() == 0) begin
               $display("%0t: unexpected result beat %h", $time, rsp_tdata);
               errors++;
            end else begin
               want = pixel_q.pop_front();
               if (got.root_class !== want.root_class)
                  $display("%0t: root_class expected %0d actual %0d", $time,
                           want.root_class, got.root_class);
               if (got.pixel_color !== want.pixel_color)
                  $display("%0t: pixel_color expected %h actual %h", $time,
                           want.pixel_color, got.pixel_color);
               if (got !== want) errors++;
               if (rsp_tdata[31:27] !== 5'b0) begin
                  $display("%0t: pad expected 0 actual %h", $time, rsp_tdata[31:27]);
                  errors++;
               end
            end
         end
         if (cycles > CYCLE_LIMIT) begin
            $display("DONE: errors detected");
            $finish;
         end
      end
   end

   task automatic wait_idle();
      while (start_q.size() != 0 || req_tvalid || accepted != issued || pixel_q.size() != 0)
         @(posedge clock);
      repeat (20) @(posedge clock);
   endtask

   task automatic write_zoom(input logic signed [10:0] value);
      @(negedge clock);
      csr_we <= 1'b1;
      csr_wdata <= value;
      zoom_shadow = value;
      @(negedge clock);
      csr_we <= 1'b0;
   endtask

   task automatic push_start(input logic [31:0] re, input logic [31:0] im);
      start_q.push_back({im, re});
   endtask

   initial begin
      logic signed [10:0] zooms[6];
      int k;
      zooms = '{11'sd0, -11'sd1024, 11'sd1023, 11'sd41, -11'sd40, 11'sd3};
      reset = 1'b1;
      req_tvalid = 1'b0;
      req_tdata = '0;
      rsp_tready = 1'b0;
      csr_we = 1'b0;
      csr_wdata = '0;
      zoom_shadow = '0;
      errors = 0; issued = 0; accepted = 0; cycles = 0;
      gap_left = 0; burst_left = 0; run_left = 0;
      repeat (10) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;
      foreach (zooms[p]) begin
         wait_idle();
         write_zoom(zooms[p]);
         if (p == 0) begin
            // zero start, unit roots, extremes, real-axis ties, tiny points
            push_start(32'h0, 32'h0);
            push_start(32'h1000_0000, 32'h0);
            push_start(32'hF800_0000, 32'h0DDB_3D74);
            push_start(32'hF800_0000, 32'hF224_C28C);
            push_start(32'h7FFF_FFFF, 32'h7FFF_FFFF);
            push_start(32'h8000_0000, 32'h8000_0000);
            push_start(32'h7FFF_FFFF, 32'h8000_0000);
            push_start(32'h8000_0000, 32'h7FFF_FFFF);
            push_start(32'hF000_0000, 32'h0);
            push_start(32'h8000_0000, 32'h0);
            push_start(32'h0, 32'h1000_0000);
            push_start(32'h0, 32'hF000_0000);
            push_start(32'h1, 32'h0);
            push_start(32'h0, 32'hFFFF_FFFF);
            push_start(32'hFFFF_FFFF, 32'h1);
            push_start(32'h0800_0000, 32'h0800_0000);
            push_start(32'hF800_0000, 32'h0);
            push_start(32'hFFFF_FFFF, 32'hFFFF_FFFF);
            push_start(32'hAAAA_AAAA, 32'h5555_5555);
            push_start(32'h5555_5555, 32'hAAAA_AAAA);
         end
         for (k = 0; k < 64; k++) begin
            if ($urandom_range(0, 7) == 0) push_start($urandom, $urandom);
            else push_start(rand_coord(), rand_coord());
         end
      end
      wait_idle();
      if (errors == 0) $display("DONE: 0 errors");
      else $display("DONE: errors detected");
      $finish;
   end
endmodule
